// File: rtl/hba_pkg.sv
// Shared types, codes and helpers for the heap block allocator.
package hba_pkg;

    // One block table entry
    typedef struct packed {
        logic [15:0] base;
        logic [16:0] len;
        logic        free;
    } t_blk;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_ZERO    = 3'd1;
    localparam t_status ST_NOSPACE = 3'd2;
    localparam t_status ST_FULL    = 3'd3;
    localparam t_status ST_BADREL  = 3'd4;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_NEXT  = 2'd3;

    localparam logic [1:0] CFG_FIT_MODE   = 2'd0;
    localparam logic [1:0] CFG_HEAP_LIMIT = 2'd1;
    localparam logic [1:0] CFG_HEADER     = 2'd2;

    localparam logic [16:0] LEN_MAX = 17'h1FFFF;

    // Add two lengths and a header, saturate at the length range
    function automatic logic [16:0] sat_sum(input logic [16:0] a, input logic [6:0] h,
                                            input logic [16:0] b);
        logic [18:0] s;
        s = {2'b00, a} + {12'd0, h} + {2'b00, b};
        return (s > {2'b00, LEN_MAX}) ? LEN_MAX : s[16:0];
    endfunction

endpackage

// File: rtl/hba_ram.sv
// Block table memory: one write port, one registered read port.
module hba_ram
    import hba_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_blk          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_blk          o_rdata
);

    t_blk mem [DEPTH];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read: the entry appears on o_rdata in the cycle after its address
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// File: rtl/heap_block_allocator_unit.sv
// Heap block allocator: fit search, split, growth and coalescing release.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+---------------------------
//  request  | i_func, i_req_size, i_release_addr     | start high, busy low
//  result   | o_data_addr, o_status                  | o_valid, one cycle
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data        | write when i_cfg_we high
//
// An item scans the block table once through the memory read port, one entry
// a cycle, then a split shifts the upper entries up and a merge shifts them down,
// each moved entry read and then written back through the single write port.
// Reset is synchronous; the table needs no clearing, the count, top and cursor are reset.
// The receiver cannot stall; one result follows each item.
module heap_block_allocator_unit
    import hba_pkg::*;
#(
    parameter int MAX_BLOCKS  = 64,
    parameter int ARENA_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_release_addr,
    output logic        o_valid,
    output logic [15:0] o_data_addr,
    output logic [2:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_CAP = (ARENA_BYTES < 65536) ? ARENA_BYTES : 65536;
    localparam logic [16:0] LIM = LIM_CAP[16:0];
    localparam logic [CW-1:0] MAXC = MAX_BLOCKS[CW-1:0];

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_GROW, S_SHUP, S_SHUP_WR, S_SPLIT_WR,
        S_WRP, S_REL_RD, S_REL_CHK, S_SHDN, S_SHDN_WR
    } t_state;

    t_state r_state;

    // Configuration
    logic [1:0]  r_fit_mode;
    logic [16:0] r_heap_limit;
    logic [6:0]  r_hdr;

    // Table control state
    logic [CW-1:0] r_count;
    logic [16:0]   r_top;
    logic [IW-1:0] r_cursor;

    // Item registers
    logic        r_func;
    logic [16:0] r_size;
    logic [15:0] r_addr;

    // Scan pipeline
    logic [CW-1:0] r_iss;
    logic          r_dv;
    logic [IW-1:0] r_didx;

    // Fit trackers
    logic          r_ff_found, r_nf_found, r_bw_found;
    logic [IW-1:0] r_ff_idx, r_nf_idx, r_bw_idx;
    logic [15:0]   r_ff_base, r_nf_base, r_bw_base;
    logic [16:0]   r_ff_len, r_nf_len, r_bw_len;

    // Chosen block
    logic [IW-1:0] r_p_idx;
    logic [15:0]   r_p_base;
    logic [16:0]   r_p_len;

    // Release match and left neighbor
    logic          r_found;
    logic [16:0]   r_l_len;
    logic [15:0]   r_l_base;
    logic          r_l_free;
    logic          r_has_r;

    // Shift loop
    logic [CW-1:0] r_sh;
    logic [1:0]    r_d;

    // Memory ports
    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    t_blk          ram_wdata, ram_rdata;

    hba_ram #(.DEPTH(MAX_BLOCKS), .AW(IW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy = (r_state != S_IDLE);

    logic        accept;
    logic [16:0] req_rnd;
    assign accept  = start && !busy;
    assign req_rnd = {1'b0, i_req_size} + 17'd3;

    // Scan-time fit test
    logic fit;
    assign fit = ram_rdata.free && (ram_rdata.len >= r_size);

    // Pick selection
    logic          pick_found;
    logic [IW-1:0] pick_idx;
    logic [15:0]   pick_base;
    logic [16:0]   pick_len;
    logic          cur_in;
    assign cur_in = ({{(CW-IW){1'b0}}, r_cursor} < r_count);

    always_comb begin
        if (r_fit_mode == FIT_BEST || r_fit_mode == FIT_WORST) begin
            pick_found = r_bw_found;
            pick_idx   = r_bw_idx;
            pick_base  = r_bw_base;
            pick_len   = r_bw_len;
        end else if (r_fit_mode == FIT_NEXT && cur_in && r_nf_found) begin
            pick_found = 1'b1;
            pick_idx   = r_nf_idx;
            pick_base  = r_nf_base;
            pick_len   = r_nf_len;
        end else begin
            pick_found = r_ff_found;
            pick_idx   = r_ff_idx;
            pick_base  = r_ff_base;
            pick_len   = r_ff_len;
        end
    end

    logic [17:0] need;
    logic        do_split;
    logic [17:0] grow_end;
    assign need     = {1'b0, r_size} + {11'd0, r_hdr};
    assign do_split = ({1'b0, pick_len} > need) && (r_count < MAXC);
    assign grow_end = {1'b0, r_top} + need;

    // Release merge arithmetic
    logic [CW-1:0] m_next;
    logic          rf, lf;
    logic [16:0]   inner_len, left_len;
    logic [IW-1:0] c1, c2;
    assign m_next    = {{(CW-IW){1'b0}}, r_p_idx} + {{(CW-1){1'b0}}, 1'b1};
    assign rf        = r_has_r && ram_rdata.free;
    assign lf        = (r_p_idx != '0) && r_l_free;
    assign inner_len = rf ? sat_sum(r_p_len, r_hdr, ram_rdata.len) : r_p_len;
    assign left_len  = sat_sum(r_l_len, r_hdr, inner_len);
    assign c1 = (rf && ({{(CW-IW){1'b0}}, r_cursor} > m_next)) ? r_cursor - 1'b1 : r_cursor;
    assign c2 = (lf && (c1 > r_p_idx)) ? c1 - 1'b1 : c1;

    logic [CW-1:0] sh_src;
    assign sh_src = r_sh + {{(CW-2){1'b0}}, r_d};

    // Memory port drive
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_p_idx;
        ram_wdata = '{base: r_p_base, len: r_p_len, free: 1'b0};
        ram_raddr = r_iss[IW-1:0];
        case (r_state)
            S_GROW: begin
                ram_we    = 1'b1;
                ram_waddr = r_count[IW-1:0];
                ram_wdata = '{base: grow_end[15:0] - r_size[15:0], len: r_size, free: 1'b0};
            end
            S_SHUP: begin
                ram_raddr = r_sh[IW-1:0] - 1'b1;
            end
            S_SHUP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sh[IW-1:0];
                ram_wdata = ram_rdata;
            end
            S_SPLIT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_p_idx + 1'b1;
                ram_wdata = '{base: r_p_base + need[15:0],
                              len: r_p_len - need[16:0], free: 1'b1};
            end
            S_WRP: begin
                ram_we = 1'b1;
            end
            S_REL_RD: begin
                ram_raddr = r_p_idx + 1'b1;
            end
            S_REL_CHK: begin
                ram_we = 1'b1;
                if (lf) begin
                    ram_waddr = r_p_idx - 1'b1;
                    ram_wdata = '{base: r_l_base, len: left_len, free: 1'b1};
                end else begin
                    ram_wdata = '{base: r_p_base, len: inner_len, free: 1'b1};
                end
            end
            S_SHDN: begin
                ram_raddr = sh_src[IW-1:0];
            end
            S_SHDN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sh[IW-1:0];
                ram_wdata = ram_rdata;
            end
            default: ;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode   <= FIT_FIRST;
            r_heap_limit <= 17'h10000;
            r_hdr        <= 7'd24;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIT_MODE:   r_fit_mode   <= i_cfg_data[1:0];
                CFG_HEAP_LIMIT: r_heap_limit <= i_cfg_data;
                CFG_HEADER:     r_hdr        <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_top      <= '0;
            r_cursor   <= '0;
            o_valid    <= 1'b0;
            r_dv       <= 1'b0;
            r_found    <= 1'b0;
            r_ff_found <= 1'b0;
            r_nf_found <= 1'b0;
            r_bw_found <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func     <= i_func;
                        r_size     <= {req_rnd[16:2], 2'b00};
                        r_addr     <= i_release_addr;
                        r_iss      <= '0;
                        r_dv       <= 1'b0;
                        r_found    <= 1'b0;
                        r_l_free   <= 1'b0;
                        r_ff_found <= 1'b0;
                        r_nf_found <= 1'b0;
                        r_bw_found <= 1'b0;
                        if (!i_func && i_req_size == 16'd0) begin
                            o_valid     <= 1'b1;
                            o_status    <= ST_ZERO;
                            o_data_addr <= '0;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue the next read, then fold in the arriving entry
                    if (r_iss < r_count) begin
                        r_iss  <= r_iss + 1'b1;
                        r_dv   <= 1'b1;
                        r_didx <= r_iss[IW-1:0];
                    end else begin
                        r_dv <= 1'b0;
                        if (!r_dv) begin
                            r_state <= S_DECIDE;
                        end
                    end
                    if (r_dv) begin
                        if (!r_func) begin
                            if (fit && !r_ff_found) begin
                                r_ff_found <= 1'b1;
                                r_ff_idx   <= r_didx;
                                r_ff_base  <= ram_rdata.base;
                                r_ff_len   <= ram_rdata.len;
                            end
                            if (fit && !r_nf_found && r_didx >= r_cursor) begin
                                r_nf_found <= 1'b1;
                                r_nf_idx   <= r_didx;
                                r_nf_base  <= ram_rdata.base;
                                r_nf_len   <= ram_rdata.len;
                            end
                            if (fit && (!r_bw_found ||
                                (r_fit_mode == FIT_BEST && ram_rdata.len < r_bw_len) ||
                                (r_fit_mode == FIT_WORST && ram_rdata.len > r_bw_len))) begin
                                r_bw_found <= 1'b1;
                                r_bw_idx   <= r_didx;
                                r_bw_base  <= ram_rdata.base;
                                r_bw_len   <= ram_rdata.len;
                            end
                        end else if (!r_found) begin
                            if (ram_rdata.base == r_addr && !ram_rdata.free) begin
                                r_found  <= 1'b1;
                                r_p_idx  <= r_didx;
                                r_p_base <= ram_rdata.base;
                                r_p_len  <= ram_rdata.len;
                            end else begin
                                r_l_free <= ram_rdata.free;
                                r_l_len  <= ram_rdata.len;
                                r_l_base <= ram_rdata.base;
                            end
                        end
                    end
                end
                S_DECIDE: begin
                    o_data_addr <= '0;
                    if (r_func) begin
                        if (!r_found) begin
                            o_valid  <= 1'b1;
                            o_status <= ST_BADREL;
                            r_state  <= S_IDLE;
                        end else begin
                            r_has_r <= (m_next < r_count);
                            r_state <= S_REL_RD;
                        end
                    end else if (pick_found) begin
                        r_p_idx  <= pick_idx;
                        r_p_base <= pick_base;
                        r_p_len  <= pick_len;
                        r_sh     <= r_count;
                        r_state  <= do_split ? S_SHUP : S_WRP;
                    end else if (r_count >= MAXC) begin
                        o_valid  <= 1'b1;
                        o_status <= ST_FULL;
                        r_state  <= S_IDLE;
                    end else if (grow_end > {1'b0, LIM} ||
                                 grow_end > {1'b0, r_heap_limit}) begin
                        o_valid  <= 1'b1;
                        o_status <= ST_NOSPACE;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_GROW;
                    end
                end
                S_GROW: begin
                    r_count     <= r_count + 1'b1;
                    r_top       <= grow_end[16:0];
                    r_cursor    <= r_count[IW-1:0];
                    o_valid     <= 1'b1;
                    o_status    <= ST_OK;
                    o_data_addr <= grow_end[15:0] - r_size[15:0];
                    r_state     <= S_IDLE;
                end
                S_SHUP: begin
                    // Move entries above the split point up by one
                    r_state <= (r_sh > m_next) ? S_SHUP_WR : S_SPLIT_WR;
                end
                S_SHUP_WR: begin
                    r_sh    <= r_sh - 1'b1;
                    r_state <= S_SHUP;
                end
                S_SPLIT_WR: begin
                    r_count <= r_count + 1'b1;
                    r_p_len <= r_size;
                    r_state <= S_WRP;
                end
                S_WRP: begin
                    r_cursor    <= r_p_idx;
                    o_valid     <= 1'b1;
                    o_status    <= ST_OK;
                    o_data_addr <= r_p_base;
                    r_state     <= S_IDLE;
                end
                S_REL_RD: begin
                    r_state <= S_REL_CHK;
                end
                S_REL_CHK: begin
                    r_cursor <= c2;
                    r_d      <= {1'b0, rf} + {1'b0, lf};
                    r_sh     <= lf ? {{(CW-IW){1'b0}}, r_p_idx} : m_next;
                    r_state  <= S_SHDN;
                end
                S_SHDN: begin
                    // Close the gap left by merged entries
                    if (sh_src < r_count) begin
                        r_state <= S_SHDN_WR;
                    end else begin
                        r_count  <= r_count - {{(CW-2){1'b0}}, r_d};
                        o_valid  <= 1'b1;
                        o_status <= ST_OK;
                        r_state  <= S_IDLE;
                    end
                end
                S_SHDN_WR: begin
                    r_sh    <= r_sh + 1'b1;
                    r_state <= S_SHDN;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXC) else $error("block count beyond table depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !(!i_func && i_req_size == 16'd0) |=> busy)
        else $error("accepted item did not occupy the sequencer");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_data_addr == 16'd0)
        else $error("failed item returned a nonzero address");

    a_top_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top != $past(r_top) |-> r_top > $past(r_top))
        else $error("heap top shrank");
`endif

endmodule
